// File: sv/bsc_pkg.sv
`timescale 1ns / 1ps
package bsc_pkg;

    localparam int MAX_PROCS = 8;
    localparam int MAX_RES   = 4;

    localparam int PROC_W    = 3;   // process index
    localparam int RES_W     = 2;   // resource index
    localparam int NPROC_W   = 4;   // process count, 0..15 as written
    localparam int NRES_W    = 3;   // resource count, 0..7 as written
    localparam int VAL_W     = 16;  // instance counts
    localparam int NEED_W    = 17;  // signed need
    localparam int WORK_W    = 20;  // working availability, avail plus all allocations
    localparam int CMP_W     = 21;  // signed compare width
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SAFE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNSAFE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXCEEDS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOAVAIL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NPROC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NRES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL3 = 3'd5;

    typedef struct packed {
        logic                accept;
        logic                load_wr;
        logic                init;
        logic                scan;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                emit_adv;
    } bsc_cmd_t;

    typedef struct packed {
        logic req_exceeds;
        logic req_noavail;
        logic scan_safe;
        logic scan_unsafe;
        logic out_free;
        logic emit_last;
    } bsc_stat_t;

endpackage

// File: sv/bsc_ctrl.sv
`timescale 1ns / 1ps
module bsc_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bsc_pkg::KIND_W-1:0]  s_kind,
    output bsc_pkg::bsc_cmd_t           cmd,
    input  bsc_pkg::bsc_stat_t          stat
);
    import bsc_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_REQ_RD  = 3'd1;
    localparam logic [2:0] S_REQ_CHK = 3'd2;
    localparam logic [2:0] S_INIT    = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.accept     = accept;
        cmd.out_status = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_LOAD: begin
                            cmd.load_wr = 1'b1;
                            status_next = ST_LOADED;
                            state_next  = S_EMIT;
                        end
                        KIND_CHECK: state_next = S_INIT;
                        KIND_REQ:   state_next = S_REQ_RD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_REQ_RD: state_next = S_REQ_CHK;
            S_REQ_CHK: begin
                if (stat.req_exceeds) begin
                    status_next = ST_EXCEEDS;
                    state_next  = S_EMIT;
                end else if (stat.req_noavail) begin
                    status_next = ST_NOAVAIL;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_safe) begin
                    status_next = ST_SAFE;
                    state_next  = S_EMIT;
                end else if (stat.scan_unsafe) begin
                    status_next = ST_UNSAFE;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.emit_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.emit_adv = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_LOADED;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    a_scan_after_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && $past(state_reg) != S_SCAN) |-> $past(state_reg) == S_INIT)
        else $error("scan started without init");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result word loaded over a pending word");

    a_req_chk_from_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REQ_CHK) |-> $past(state_reg) == S_REQ_RD)
        else $error("request check without table read");

endmodule

// File: sv/bsc_datapath.sv
`timescale 1ns / 1ps
module bsc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bsc_pkg::bsc_cmd_t               cmd,
    output bsc_pkg::bsc_stat_t              stat,
    input  logic [bsc_pkg::KIND_W-1:0]      s_kind,
    input  logic [bsc_pkg::PROC_W-1:0]      s_proc_id,
    input  logic [bsc_pkg::RES_W-1:0]       s_res_index,
    input  logic [bsc_pkg::VAL_W-1:0]       s_max_value,
    input  logic [bsc_pkg::VAL_W-1:0]       s_alloc_value,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_0,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_1,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_2,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_3,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bsc_pkg::STATUS_W-1:0]    m_status,
    output logic [bsc_pkg::PROC_W-1:0]      m_seq_proc,
    output logic                            m_last
);
    import bsc_pkg::*;

    // configuration
    logic [NPROC_W-1:0] nproc_reg;
    logic [NRES_W-1:0]  nres_reg;
    logic [VAL_W-1:0]   avail_reg [MAX_RES];
    logic [NPROC_W-1:0] n_eff;
    logic [NRES_W-1:0]  m_eff;
    logic [MAX_RES-1:0] lane_on;

    // latched item
    logic [PROC_W-1:0]  pid_reg;
    logic               req_mode_reg;
    logic [VAL_W-1:0]   req_reg [MAX_RES];

    // tables, one row per process, one column per resource
    logic [VAL_W-1:0]          alloc_mem [MAX_RES][MAX_PROCS];
    logic signed [NEED_W-1:0]  need_mem  [MAX_RES][MAX_PROCS];
    logic [VAL_W-1:0]          rd_alloc  [MAX_RES];
    logic signed [NEED_W-1:0]  rd_need   [MAX_RES];
    logic [PROC_W-1:0]         rd_addr;

    // scan state
    logic [WORK_W-1:0]   work_reg [MAX_RES];
    logic [MAX_PROCS-1:0] finish_reg;
    logic [PROC_W-1:0]   seq_arr [MAX_PROCS];
    logic [NPROC_W-1:0]  done_reg;
    logic [NPROC_W-1:0]  stall_reg;
    logic [PROC_W-1:0]   idx_reg;
    logic [PROC_W-1:0]   idx_wrap;

    logic [PROC_W-1:0]   emit_idx_reg;

    logic m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [PROC_W-1:0]   m_seq_reg;
    logic                m_last_reg;

    logic signed [CMP_W-1:0] need_eff [MAX_RES];
    logic [WORK_W-1:0]       alloc_add [MAX_RES];
    logic [MAX_RES-1:0]      lane_fit;
    logic [MAX_RES-1:0]      lane_exc;
    logic [MAX_RES-1:0]      lane_noav;
    logic                    overlay;
    logic                    visit_fit;
    logic                    is_safe;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (nproc_reg == '0) begin
            n_eff = NPROC_W'(1);
        end else if (nproc_reg > NPROC_W'(MAX_PROCS)) begin
            n_eff = NPROC_W'(MAX_PROCS);
        end else begin
            n_eff = nproc_reg;
        end
        if (nres_reg == '0) begin
            m_eff = NRES_W'(1);
        end else if (nres_reg > NRES_W'(MAX_RES)) begin
            m_eff = NRES_W'(MAX_RES);
        end else begin
            m_eff = nres_reg;
        end
        for (int j = 0; j < MAX_RES; j++) begin
            lane_on[j] = (j < int'(m_eff));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nproc_reg <= NPROC_W'(MAX_PROCS);
            nres_reg  <= NRES_W'(MAX_RES);
            for (int j = 0; j < MAX_RES; j++) begin
                avail_reg[j] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NPROC:  nproc_reg    <= cfg_data[NPROC_W-1:0];
                CFG_NRES:   nres_reg     <= cfg_data[NRES_W-1:0];
                CFG_AVAIL0: avail_reg[0] <= cfg_data;
                CFG_AVAIL1: avail_reg[1] <= cfg_data;
                CFG_AVAIL2: avail_reg[2] <= cfg_data;
                CFG_AVAIL3: avail_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pid_reg      <= s_proc_id;
            req_mode_reg <= (s_kind == KIND_REQ);
            req_reg[0]   <= s_req_0;
            req_reg[1]   <= s_req_1;
            req_reg[2]   <= s_req_2;
            req_reg[3]   <= s_req_3;
        end
    end

    // scan reads the row it will visit next, init reads row 0; otherwise the requesting row
    assign idx_wrap = (({1'b0, idx_reg} + 1'b1) == n_eff) ? '0 : idx_reg + 1'b1;

    always_comb begin
        if (cmd.scan) begin
            rd_addr = idx_wrap;
        end else if (cmd.init) begin
            rd_addr = '0;
        end else begin
            rd_addr = pid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            alloc_mem[s_res_index][s_proc_id] <= s_alloc_value;
            need_mem[s_res_index][s_proc_id]  <=
                $signed({1'b0, s_max_value}) - $signed({1'b0, s_alloc_value});
        end
        for (int j = 0; j < MAX_RES; j++) begin
            rd_alloc[j] <= alloc_mem[j][rd_addr];
            rd_need[j]  <= need_mem[j][rd_addr];
        end
    end

    // a pending request is applied on the fly to its own row, never written back
    always_comb begin
        overlay = req_mode_reg && (idx_reg == pid_reg);
        for (int j = 0; j < MAX_RES; j++) begin
            need_eff[j]  = CMP_W'(rd_need[j]);
            alloc_add[j] = WORK_W'(rd_alloc[j]);
            if (overlay && lane_on[j]) begin
                need_eff[j]  = need_eff[j] - $signed({{(CMP_W-VAL_W){1'b0}}, req_reg[j]});
                alloc_add[j] = alloc_add[j] + WORK_W'(req_reg[j]);
            end
            lane_fit[j]  = !lane_on[j] || (need_eff[j] <= $signed({1'b0, work_reg[j]}));
            lane_exc[j]  = lane_on[j] &&
                ($signed({{(CMP_W-VAL_W){1'b0}}, req_reg[j]}) > CMP_W'(rd_need[j]));
            lane_noav[j] = lane_on[j] && (req_reg[j] > avail_reg[j]);
        end
        visit_fit = !finish_reg[idx_reg] && (&lane_fit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            done_reg   <= '0;
            stall_reg  <= '0;
            finish_reg <= '0;
            for (int j = 0; j < MAX_RES; j++) begin
                work_reg[j] <= '0;
            end
        end else if (cmd.init) begin
            idx_reg    <= '0;
            done_reg   <= '0;
            stall_reg  <= '0;
            finish_reg <= '0;
            for (int j = 0; j < MAX_RES; j++) begin
                work_reg[j] <= WORK_W'(avail_reg[j]) -
                    ((req_mode_reg && lane_on[j]) ? WORK_W'(req_reg[j]) : '0);
            end
        end else if (cmd.scan) begin
            idx_reg <= idx_wrap;
            if (visit_fit) begin
                finish_reg[idx_reg]           <= 1'b1;
                seq_arr[done_reg[PROC_W-1:0]] <= idx_reg;
                done_reg                      <= done_reg + 1'b1;
                stall_reg                     <= '0;
                for (int j = 0; j < MAX_RES; j++) begin
                    if (lane_on[j]) begin
                        work_reg[j] <= work_reg[j] + alloc_add[j];
                    end
                end
            end else begin
                stall_reg <= stall_reg + 1'b1;
            end
        end
    end

    // result words
    assign is_safe = (cmd.out_status == ST_SAFE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                emit_idx_reg <= '0;
            end else if (cmd.emit_adv) begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_status;
            m_seq_reg    <= is_safe ? seq_arr[emit_idx_reg] : '0;
            m_last_reg   <= stat.emit_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_seq_proc = m_seq_reg;
    assign m_last     = m_last_reg;

    always_comb begin
        stat.req_exceeds = ({1'b0, pid_reg} >= n_eff) || (|lane_exc);
        stat.req_noavail = |lane_noav;
        stat.scan_safe   = visit_fit && ((done_reg + 1'b1) == n_eff);
        stat.scan_unsafe = !visit_fit && ((stall_reg + 1'b1) >= n_eff);
        stat.out_free    = !m_valid_reg || m_ready;
        stat.emit_last   = !is_safe || (({1'b0, emit_idx_reg} + 1'b1) == n_eff);
    end

    a_finish_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(finish_reg) == int'(done_reg))
        else $error("finished flags disagree with sequence length");

    a_scan_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> !(stat.scan_safe && stat.scan_unsafe))
        else $error("scan both safe and unsafe");

    a_visit_clears_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && visit_fit) |=> stall_reg == '0)
        else $error("stall count not cleared on progress");

endmodule

// File: sv/bankers_safety_check.sv
`timescale 1ns / 1ps
// Banker's deadlock-avoidance checker. Each input word is a table load, a safety
// check or a resource request; results come out as words on the m_ channel, a
// safe outcome as n words giving the safe sequence (last on the final one), every
// other outcome as a single word. A safety check runs an init step and then a
// round-robin scan of process visits (n to about n*n visits, at most
// 8 + 7*8 = 64 for n = 8), then its result words; a request first reads and checks
// its table row and, unless refused, then runs the same scan. The scan rate is set
// by the single table read port: one process row is read and compared across all
// resources in use per cycle. A request never modifies the tables; it is applied
// to the working copy during the scan only. Configuration writes are accepted
// every cycle and must be made while idle.
module bankers_safety_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bsc_pkg::KIND_W-1:0]      s_kind,
    input  logic [bsc_pkg::PROC_W-1:0]      s_proc_id,
    input  logic [bsc_pkg::RES_W-1:0]       s_res_index,
    input  logic [bsc_pkg::VAL_W-1:0]       s_max_value,
    input  logic [bsc_pkg::VAL_W-1:0]       s_alloc_value,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_0,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_1,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_2,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_3,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bsc_pkg::STATUS_W-1:0]    m_status,
    output logic [bsc_pkg::PROC_W-1:0]      m_seq_proc,
    output logic                            m_last
);
    import bsc_pkg::*;

    bsc_cmd_t  cmd;
    bsc_stat_t stat;

    bsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .cmd     (cmd),
        .stat    (stat)
    );

    bsc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_kind        (s_kind),
        .s_proc_id     (s_proc_id),
        .s_res_index   (s_res_index),
        .s_max_value   (s_max_value),
        .s_alloc_value (s_alloc_value),
        .s_req_0       (s_req_0),
        .s_req_1       (s_req_1),
        .s_req_2       (s_req_2),
        .s_req_3       (s_req_3),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_seq_proc    (m_seq_proc),
        .m_last        (m_last)
    );

endmodule

// File: test/bsc_result_checker.sv
`timescale 1ns / 1ps
module bsc_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [bsc_pkg::KIND_W-1:0]      s_kind,
    input  logic [bsc_pkg::PROC_W-1:0]      s_proc_id,
    input  logic [bsc_pkg::RES_W-1:0]       s_res_index,
    input  logic [bsc_pkg::VAL_W-1:0]       s_max_value,
    input  logic [bsc_pkg::VAL_W-1:0]       s_alloc_value,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_0,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_1,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_2,
    input  logic [bsc_pkg::VAL_W-1:0]       s_req_3,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [bsc_pkg::STATUS_W-1:0]    m_status,
    input  logic [bsc_pkg::PROC_W-1:0]      m_seq_proc,
    input  logic                            m_last,
    output int                              n_pending,
    output int                              n_errors,
    output int                              n_safe,
    output int                              n_unsafe,
    output int                              n_refused
);
    import bsc_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PROC_W-1:0]   seq_proc;
        logic                last;
    } result_word_t;

    result_word_t words_due [$];

    logic [NPROC_W-1:0]       reg_nproc;
    logic [NRES_W-1:0]        reg_nres;
    logic [VAL_W-1:0]         reg_avail [MAX_RES];
    logic [VAL_W-1:0]         alloc_tab [MAX_PROCS][MAX_RES];
    logic signed [NEED_W-1:0] need_tab  [MAX_PROCS][MAX_RES];

    initial begin
        reg_nproc = NPROC_W'(MAX_PROCS);
        reg_nres  = NRES_W'(MAX_RES);
        for (int i = 0; i < MAX_PROCS; i++) begin
            for (int j = 0; j < MAX_RES; j++) begin
                alloc_tab[i][j] = '0;
                need_tab[i][j]  = '0;
            end
        end
        for (int j = 0; j < MAX_RES; j++) begin
            reg_avail[j] = '0;
        end
        n_pending = 0;
        n_errors  = 0;
        n_safe    = 0;
        n_unsafe  = 0;
        n_refused = 0;
    end

    // counts of zero act as one, oversized counts saturate
    function automatic int procs_in_use();
        if (reg_nproc == 0) return 1;
        if (reg_nproc > MAX_PROCS) return MAX_PROCS;
        return int'(reg_nproc);
    endfunction

    function automatic int res_in_use();
        if (reg_nres == 0) return 1;
        if (reg_nres > MAX_RES) return MAX_RES;
        return int'(reg_nres);
    endfunction

    task automatic queue_word(input logic [STATUS_W-1:0] st, input logic [PROC_W-1:0] sp,
                              input logic lst);
        result_word_t w;
        w.status   = st;
        w.seq_proc = sp;
        w.last     = lst;
        words_due.push_back(w);
    endtask

    // round-robin safety scan over the current tables and availability
    task automatic run_safety_scan();
        int n, m, idx, done, misses;
        int work [MAX_RES];
        bit finished [MAX_PROCS];
        bit fits, running;
        logic [PROC_W-1:0] order [MAX_PROCS];
        n = procs_in_use();
        m = res_in_use();
        for (int j = 0; j < MAX_RES; j++) begin
            work[j] = int'(reg_avail[j]);
        end
        for (int i = 0; i < MAX_PROCS; i++) begin
            finished[i] = 1'b0;
            order[i]    = '0;
        end
        idx     = 0;
        done    = 0;
        misses  = 0;
        running = 1'b1;
        while (running) begin
            if (!finished[idx]) begin
                fits = 1'b1;
                for (int j = 0; j < m; j++) begin
                    if (int'(need_tab[idx][j]) > work[j]) fits = 1'b0;
                end
                if (fits) begin
                    misses = 0;
                    for (int j = 0; j < m; j++) begin
                        work[j] = work[j] + int'(alloc_tab[idx][j]);
                    end
                    finished[idx] = 1'b1;
                    order[done]   = PROC_W'(idx);
                    done++;
                    if (done == n) running = 1'b0;
                end else begin
                    misses++;
                end
            end else begin
                misses++;
            end
            // n visits in a row without progress: stuck
            if (running && misses >= n) running = 1'b0;
            idx = (idx + 1) % n;
        end
        if (done == n) begin
            for (int j = 0; j < n; j++) begin
                queue_word(ST_SAFE, order[j], j == n - 1);
            end
            n_safe++;
        end else begin
            queue_word(ST_UNSAFE, '0, 1'b1);
            n_unsafe++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        int p, m;
        logic [VAL_W-1:0]         want       [MAX_RES];
        logic [VAL_W-1:0]         kept_avail [MAX_RES];
        logic [VAL_W-1:0]         kept_alloc [MAX_RES];
        logic signed [NEED_W-1:0] kept_need  [MAX_RES];
        logic over_claim, short_supply;
        result_word_t due;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NPROC:  reg_nproc    = cfg_data[NPROC_W-1:0];
                    CFG_NRES:   reg_nres     = cfg_data[NRES_W-1:0];
                    CFG_AVAIL0: reg_avail[0] = cfg_data;
                    CFG_AVAIL1: reg_avail[1] = cfg_data;
                    CFG_AVAIL2: reg_avail[2] = cfg_data;
                    CFG_AVAIL3: reg_avail[3] = cfg_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                case (s_kind)
                    KIND_LOAD: begin
                        alloc_tab[s_proc_id][s_res_index] = s_alloc_value;
                        need_tab[s_proc_id][s_res_index] =
                            $signed({1'b0, s_max_value}) - $signed({1'b0, s_alloc_value});
                        queue_word(ST_LOADED, '0, 1'b1);
                    end
                    KIND_CHECK: begin
                        run_safety_scan();
                    end
                    KIND_REQ: begin
                        p       = int'(s_proc_id);
                        m       = res_in_use();
                        want[0] = s_req_0;
                        want[1] = s_req_1;
                        want[2] = s_req_2;
                        want[3] = s_req_3;
                        over_claim   = (p >= procs_in_use());
                        short_supply = 1'b0;
                        for (int j = 0; j < m; j++) begin
                            if ($signed({1'b0, want[j]}) > need_tab[p][j]) over_claim = 1'b1;
                            if (want[j] > reg_avail[j]) short_supply = 1'b1;
                        end
                        if (over_claim) begin
                            queue_word(ST_EXCEEDS, '0, 1'b1);
                            n_refused++;
                        end else if (short_supply) begin
                            queue_word(ST_NOAVAIL, '0, 1'b1);
                            n_refused++;
                        end else begin
                            // grant tentatively, scan, then roll back
                            for (int j = 0; j < MAX_RES; j++) begin
                                kept_avail[j] = reg_avail[j];
                                kept_alloc[j] = alloc_tab[p][j];
                                kept_need[j]  = need_tab[p][j];
                            end
                            for (int j = 0; j < m; j++) begin
                                reg_avail[j]    = reg_avail[j] - want[j];
                                alloc_tab[p][j] = alloc_tab[p][j] + want[j];
                                need_tab[p][j]  = need_tab[p][j] - $signed({1'b0, want[j]});
                            end
                            run_safety_scan();
                            for (int j = 0; j < MAX_RES; j++) begin
                                reg_avail[j]    = kept_avail[j];
                                alloc_tab[p][j] = kept_alloc[j];
                                need_tab[p][j]  = kept_need[j];
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (words_due.size() == 0) begin
                    $error("unexpected result word: status %0d seq_proc %0d last %0b",
                           m_status, m_seq_proc, m_last);
                    n_errors++;
                end else begin
                    due = words_due.pop_front();
                    if (m_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, m_status);
                        n_errors++;
                    end
                    if (m_seq_proc !== due.seq_proc) begin
                        $error("seq_proc: expected %0d, got %0d", due.seq_proc, m_seq_proc);
                        n_errors++;
                    end
                    if (m_last !== due.last) begin
                        $error("last: expected %0b, got %0b", due.last, m_last);
                        n_errors++;
                    end
                end
            end
            n_pending = words_due.size();
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bsc_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 220;
    localparam int PHASE_ITEMS  = 30;

    // kind code the block ignores
    localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic [KIND_W-1:0]     s_kind        = '0;
    logic [PROC_W-1:0]     s_proc_id     = '0;
    logic [RES_W-1:0]      s_res_index   = '0;
    logic [VAL_W-1:0]      s_max_value   = '0;
    logic [VAL_W-1:0]      s_alloc_value = '0;
    logic [VAL_W-1:0]      s_req_0       = '0;
    logic [VAL_W-1:0]      s_req_1       = '0;
    logic [VAL_W-1:0]      s_req_2       = '0;
    logic [VAL_W-1:0]      s_req_3       = '0;
    logic                  cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  m_ready       = 1'b0;
    logic                  s_ready;
    logic                  cfg_ready;
    logic                  m_valid;
    logic [STATUS_W-1:0]   m_status;
    logic [PROC_W-1:0]     m_seq_proc;
    logic                  m_last;

    int n_pending, n_errors, n_safe, n_unsafe, n_refused;

    bit no_idle  = 1'b0;
    bit hold_off = 1'b0;
    bit loaded [MAX_PROCS][MAX_RES];
    int use_n = MAX_PROCS;
    int use_m = MAX_RES;
    int words_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    bankers_safety_check i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_proc_id     (s_proc_id),
        .s_res_index   (s_res_index),
        .s_max_value   (s_max_value),
        .s_alloc_value (s_alloc_value),
        .s_req_0       (s_req_0),
        .s_req_1       (s_req_1),
        .s_req_2       (s_req_2),
        .s_req_3       (s_req_3),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_seq_proc    (m_seq_proc),
        .m_last        (m_last)
    );

    bsc_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_proc_id     (s_proc_id),
        .s_res_index   (s_res_index),
        .s_max_value   (s_max_value),
        .s_alloc_value (s_alloc_value),
        .s_req_0       (s_req_0),
        .s_req_1       (s_req_1),
        .s_req_2       (s_req_2),
        .s_req_3       (s_req_3),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_seq_proc    (m_seq_proc),
        .m_last        (m_last),
        .n_pending     (n_pending),
        .n_errors      (n_errors),
        .n_safe        (n_safe),
        .n_unsafe      (n_unsafe),
        .n_refused     (n_refused)
    );

    // no word accepted on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // result side: random backpressure plus one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= 37);
        end
    end

    function automatic logic [VAL_W-1:0] any_count(input int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return VAL_W'($urandom_range(0, top));
        if (r < 90) return VAL_W'($urandom);
        if (r < 95) return '1;
        return '0;
    endfunction

    // reports the first entry a scan of the current size would read unwritten
    function automatic bit table_ready(output logic [PROC_W-1:0] pi,
                                       output logic [RES_W-1:0] ri);
        pi = '0;
        ri = '0;
        for (int i = 0; i < use_n; i++) begin
            for (int j = 0; j < use_m; j++) begin
                if (!loaded[i][j]) begin
                    pi = PROC_W'(i);
                    ri = RES_W'(j);
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [PROC_W-1:0] pid,
                             input logic [RES_W-1:0] ri, input logic [VAL_W-1:0] mx,
                             input logic [VAL_W-1:0] al, input logic [VAL_W-1:0] r0,
                             input logic [VAL_W-1:0] r1, input logic [VAL_W-1:0] r2,
                             input logic [VAL_W-1:0] r3);
        if (!no_idle && $urandom_range(0, 99) < 37) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < 37);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_proc_id     <= pid;
        s_res_index   <= ri;
        s_max_value   <= mx;
        s_alloc_value <= al;
        s_req_0       <= r0;
        s_req_1       <= r1;
        s_req_2       <= r2;
        s_req_3       <= r3;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (kind == KIND_LOAD) loaded[pid][ri] = 1'b1;
        if (kind != KIND_RSVD) words_sent++;
    endtask

    task automatic send_load(input logic [PROC_W-1:0] pid, input logic [RES_W-1:0] ri,
                             input logic [VAL_W-1:0] mx, input logic [VAL_W-1:0] al);
        send_word(KIND_LOAD, pid, ri, mx, al, VAL_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic send_check();
        send_word(KIND_CHECK, PROC_W'($urandom), RES_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic send_request(input logic [PROC_W-1:0] pid, input logic [VAL_W-1:0] r0,
                                input logic [VAL_W-1:0] r1, input logic [VAL_W-1:0] r2,
                                input logic [VAL_W-1:0] r3);
        send_word(KIND_REQ, pid, RES_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                  r0, r1, r2, r3);
    endtask

    task automatic send_noise();
        send_word(KIND_RSVD, PROC_W'($urandom), RES_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // only touched once the block has drained
    task automatic apply_config(input logic [NPROC_W-1:0] np, input logic [NRES_W-1:0] nr,
                                input logic [VAL_W-1:0] a0, input logic [VAL_W-1:0] a1,
                                input logic [VAL_W-1:0] a2, input logic [VAL_W-1:0] a3);
        logic [CFG_DATA_W-1:0] word_np, word_nr;
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        // unused upper bits carry noise
        word_np = CFG_DATA_W'($urandom);
        word_np[NPROC_W-1:0] = np;
        word_nr = CFG_DATA_W'($urandom);
        word_nr[NRES_W-1:0] = nr;
        write_reg(CFG_NPROC, word_np);
        write_reg(CFG_NRES, word_nr);
        write_reg(CFG_AVAIL0, a0);
        write_reg(CFG_AVAIL1, a1);
        write_reg(CFG_AVAIL2, a2);
        write_reg(CFG_AVAIL3, a3);
        cfg_valid <= 1'b0;
        use_n = (np == 0) ? 1 : (np > MAX_PROCS) ? MAX_PROCS : int'(np);
        use_m = (nr == 0) ? 1 : (nr > MAX_RES) ? MAX_RES : int'(nr);
        settings_used++;
    endtask

    task automatic random_item();
        int pick;
        logic [PROC_W-1:0] pi;
        logic [RES_W-1:0] ri;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            send_noise();
        end else if (pick < 24) begin
            send_load(PROC_W'($urandom), RES_W'($urandom), any_count(12), any_count(8));
        end else if (!table_ready(pi, ri)) begin
            send_load(pi, ri, any_count(12), any_count(8));
        end else if (pick < 60) begin
            send_check();
        end else begin
            if ($urandom_range(0, 9) < 8) pi = PROC_W'($urandom_range(0, use_n - 1));
            else pi = PROC_W'($urandom);
            send_request(pi, any_count(2), any_count(2), any_count(2), any_count(2));
        end
    endtask

    initial begin
        int start_count;
        int phase;
        for (int i = 0; i < MAX_PROCS; i++) begin
            for (int j = 0; j < MAX_RES; j++) begin
                loaded[i][j] = 1'b0;
            end
        end
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: two processes, one resource type
        apply_config(4'd2, 3'd1, 16'd3, 16'd0, 16'd0, 16'd0);
        send_load(3'd0, 2'd0, 16'd4, 16'd1);
        send_load(3'd1, 2'd0, 16'd2, 16'd2);
        send_check();
        send_request(3'd0, 16'd4, 16'd0, 16'd0, 16'd0);
        // types beyond the count in use are not looked at
        send_request(3'd0, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(3'd7, 16'd0, 16'd0, 16'd0, 16'd0);
        send_load(3'd1, 2'd0, 16'd9, 16'd2);
        send_request(3'd0, 16'd2, 16'd0, 16'd0, 16'd0);
        send_check();
        send_load(3'd0, 2'd0, 16'd20, 16'd0);
        send_request(3'd0, 16'd10, 16'd0, 16'd0, 16'd0);
        // allocation above the claim: negative need
        send_load(3'd1, 2'd0, 16'd0, 16'hFFFF);
        send_check();
        send_request(3'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        send_noise();
        send_load(3'd7, 2'd3, 16'hFFFF, 16'hFFFF);
        // zero counts behave as one
        apply_config(4'd0, 3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_load(3'd0, 2'd0, 16'hFFFF, 16'd0);
        send_check();
        send_request(3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_request(3'd1, 16'd0, 16'd0, 16'd0, 16'd0);

        start_count = words_sent;
        phase = 0;
        while (words_sent - start_count < RANDOM_ITEMS) begin
            case (phase)
                0: apply_config(4'd15, 3'd7, any_count(20), any_count(20), any_count(20),
                                any_count(20));
                1: apply_config(4'd8, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: apply_config(4'd1, 3'd1, 16'd0, 16'd0, 16'd0, 16'd0);
                default: apply_config(NPROC_W'($urandom), NRES_W'($urandom), any_count(20),
                                      any_count(20), any_count(20), any_count(20));
            endcase
            if (phase == 3) hold_off = 1'b1;
            no_idle = (phase == 4);
            repeat (PHASE_ITEMS) random_item();
            phase++;
        end
        no_idle = 1'b0;

        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("summary: %0d words over %0d settings; %0d safe, %0d unsafe, %0d refused",
                 words_sent, settings_used, n_safe, n_unsafe, n_refused);
        if (n_errors == 0 && n_pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
